FILE: rtl/core/afrd_pkg.sv
// Package with the delimiter, escape and checksum codes, phase encoding and result type of the API frame receiver.
`timescale 1ns / 1ps

package afrd_pkg;

  localparam logic [7:0] Delim   = 8'h7E;
  localparam logic [7:0] Esc     = 8'h7D;
  localparam logic [7:0] EscXor  = 8'h20;
  localparam logic [7:0] SumGood = 8'hFF;

  typedef enum logic [4:0] {
    PhHunt  = 5'b00001,
    PhLenHi = 5'b00010,
    PhLenLo = 5'b00100,
    PhData  = 5'b01000,
    PhCsum  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       checksum_ok;
  } result_t;

endpackage

FILE: rtl/core/api_frame_receive_deframer_core.sv
// Top level of the API frame receiver: delimiter hunt, unescape, length count, checksum.
`timescale 1ns / 1ps

//  channel  | direction | tdata            | tlast     | tuser
//  s_axis   | in        | [7:0] rx_byte    | -         | -
//  m_axis   | out       | [7:0] payload    | frame_end | checksum_ok
//
// One raw byte per cycle while the result is not stalled: a byte is registered at the
// input, then the phase logic updates the frame state and loads the result register.
// A stalled result holds the processing stage; the input register still takes one
// byte. Reset returns to the delimiter hunt with the sum and length cleared.

module api_frame_receive_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,   // frame_end
  output logic       m_axis_tuser    // [0] checksum_ok
);
  import afrd_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_q, res;
  logic       has_res;
  logic       proc_fire;
  phase_e     phase_q, phase_d;
  logic       esc_q, esc_d;
  logic [15:0] remain_q, remain_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] v;
  logic [7:0] sum_chk;

  assign proc_fire     = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc_fire;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (proc_fire) begin
      in_vld_d = 1'b0;
    end
  end

  // Frame state update for the registered byte
  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    has_res  = 1'b0;
    res      = '0;
    v        = esc_q ? (in_byte_q ^ EscXor) : in_byte_q;
    sum_chk  = sum_q + v;
    unique case (phase_q)
      PhLenHi, PhLenLo, PhData, PhCsum: begin
        if (!esc_q && in_byte_q == Delim) begin
          // restart the frame
          phase_d  = PhLenHi;
          sum_d    = '0;
          remain_d = '0;
        end else if (!esc_q && in_byte_q == Esc) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          unique case (phase_q)
            PhLenHi: begin
              remain_d = {8'h00, v};
              phase_d  = PhLenLo;
            end
            PhLenLo: begin
              remain_d = {remain_q[7:0], v};
              phase_d  = ({remain_q[7:0], v} == 16'h0000) ? PhCsum : PhData;
            end
            PhData: begin
              sum_d    = sum_chk;
              remain_d = remain_q - 16'd1;
              if (remain_q == 16'd1) begin
                phase_d = PhCsum;
              end
              has_res          = 1'b1;
              res.payload_byte = v;
            end
            default: begin
              has_res         = 1'b1;
              res.frame_end   = 1'b1;
              res.checksum_ok = (sum_chk == SumGood);
              phase_d         = PhHunt;
              sum_d           = '0;
              remain_d        = '0;
            end
          endcase
        end
      end
      default: begin
        // hunt: drop everything but the delimiter
        phase_d = PhHunt;
        esc_d   = 1'b0;
        if (in_byte_q == Delim) begin
          phase_d  = PhLenHi;
          sum_d    = '0;
          remain_d = '0;
        end
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (proc_fire && has_res) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PhHunt;
      esc_q     <= 1'b0;
      remain_q  <= '0;
      sum_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (proc_fire) begin
        phase_q  <= phase_d;
        esc_q    <= esc_d;
        remain_q <= remain_d;
        sum_q    <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (proc_fire && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.payload_byte;
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tuser  = out_q.checksum_ok;

`ifndef SYNTHESIS
  a_end_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
    else $error("end item carries nonzero payload");

  a_ok_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser)
    else $error("checksum flag on data item");

  a_hunt_no_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHunt |-> !esc_q)
    else $error("escape pending while hunting");

  a_len_hi_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhLenHi |-> sum_q == 8'h00)
    else $error("running sum not cleared at frame start");

  a_data_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> remain_q != 16'h0000)
    else $error("data phase with no bytes remaining");

  a_input_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted byte not held in input register");
`endif

endmodule

FILE: sim/afrd_checker.sv
// Checker for the API frame receiver: predicts results from accepted bytes and compares.
`timescale 1ns / 1ps

module afrd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_payload_i,
  input  logic       out_last_i,
  input  logic       out_user_i,
  output int         fail_count_o,
  output int         pending_o
);

  import afrd_pkg::*;

  phase_e      frame_phase;
  logic        escape_armed;
  logic [15:0] data_left;
  logic [7:0]  data_sum;

  result_t     frame_results_q[$];
  result_t     predicted;
  result_t     oldest;
  int          errors = 0;

  // Advance the frame state by one raw byte; return 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] raw, output result_t res);
    logic [7:0] value;
    res = '0;
    if (frame_phase == PhHunt) begin
      escape_armed = 1'b0;
      if (raw == Delim) begin
        frame_phase = PhLenHi;
        data_sum    = '0;
        data_left   = '0;
      end
      return 1'b0;
    end
    if (escape_armed) begin
      escape_armed = 1'b0;
      value        = raw ^ EscXor;
    end else if (raw == Delim) begin
      // unescaped delimiter: drop the current frame and start over
      frame_phase = PhLenHi;
      data_sum    = '0;
      data_left   = '0;
      return 1'b0;
    end else if (raw == Esc) begin
      escape_armed = 1'b1;
      return 1'b0;
    end else begin
      value = raw;
    end
    case (frame_phase)
      PhLenHi: begin
        data_left   = {8'h00, value};
        frame_phase = PhLenLo;
        return 1'b0;
      end
      PhLenLo: begin
        data_left   = {data_left[7:0], value};
        frame_phase = (data_left == '0) ? PhCsum : PhData;
        return 1'b0;
      end
      PhData: begin
        data_sum  = data_sum + value;
        data_left = data_left - 16'd1;
        if (data_left == '0) frame_phase = PhCsum;
        res.payload_byte = value;
        return 1'b1;
      end
      default: begin
        res.frame_end   = 1'b1;
        res.checksum_ok = (8'(data_sum + value) == SumGood);
        frame_phase     = PhHunt;
        data_sum        = '0;
        data_left       = '0;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase  = PhHunt;
      escape_armed = 1'b0;
      data_left    = '0;
      data_sum     = '0;
      frame_results_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_results_q.size() == 0) begin
          if (errors < 10)
            $display("%t: unexpected result payload=%02h end=%0b ok=%0b", $realtime,
                     out_payload_i, out_last_i, out_user_i);
          errors++;
        end else begin
          oldest = frame_results_q.pop_front();
          if (oldest.payload_byte !== out_payload_i || oldest.frame_end !== out_last_i ||
              oldest.checksum_ok !== out_user_i) begin
            if (errors < 10)
              $display("%t: expected data=%02h end=%0b ok=%0b, got data=%02h end=%0b ok=%0b",
                       $realtime, oldest.payload_byte, oldest.frame_end, oldest.checksum_ok,
                       out_payload_i, out_last_i, out_user_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(in_byte_i, predicted)) frame_results_q.push_back(predicted);
      end
      pending_o    <= frame_results_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the API frame receiver: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  import afrd_pkg::*;

  localparam logic [7:0] XOn  = 8'h11;
  localparam logic [7:0] XOff = 8'h13;
  localparam int         BytesPerPhase = 310;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  int mismatch_count;
  int expected_pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int frame_bytes_sent = 0;
  bit line_idle = 1'b1;

  int idle_tab[4]  = '{0, 80, 0, 10};
  int stall_tab[4] = '{0, 0, 80, 10};

  // hunt noise, zero length, escaped length and data, restart mid-length, escaped delimiter
  logic [7:0] directed_seq[25] = '{
    8'h00, 8'h7D,
    8'h7E, 8'h00, 8'h00, 8'hFF,
    8'h7E, 8'h00, 8'h7D, 8'h23, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'hFF, 8'h05,
    8'h7E, 8'h00, 8'h05, 8'h7E, 8'h00, 8'h01, 8'h7D, 8'h7E, 8'h00
  };

  always #5 clk_i = ~clk_i;

  api_frame_receive_deframer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  afrd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_payload_i (m_axis_tdata),
    .out_last_i    (m_axis_tlast),
    .out_user_i    (m_axis_tuser),
    .fail_count_o  (mismatch_count),
    .pending_o     (expected_pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Drive one byte and hold it until the transaction completes.
  task automatic send_byte(input logic [7:0] raw, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counted) frame_bytes_sent++;
  endtask

  // Escape the bytes that must be escaped, and some others at random.
  task automatic send_coded(input logic [7:0] value);
    if (value == Delim || value == Esc || value == XOn || value == XOff ||
        $urandom_range(99) < 10) begin
      send_byte(Esc, 1'b1);
      send_byte(value ^ EscXor, 1'b1);
    end else begin
      send_byte(value, 1'b1);
    end
  endtask

  task automatic send_frame();
    logic [15:0] len;
    logic [7:0]  data_sum;
    logic [7:0]  value;
    int          pick;
    int          n_data;
    bit          cut;
    if (line_idle && $urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 3)) begin
        value = 8'($urandom_range(255));
        if (value == Delim) value = 8'h00;
        send_byte(value, 1'b0);
      end
    end
    pick = $urandom_range(99);
    cut  = ($urandom_range(99) < 5);
    if (pick < 90) begin
      len = 16'($urandom_range(0, 12));
    end else if (pick < 96) begin
      len = 16'($urandom_range(13, 60));
    end else begin
      // long declared length: always cut short by the next delimiter
      len = 16'($urandom_range(256, 65535));
      cut = 1'b1;
    end
    n_data = cut ? $urandom_range(0, (len < 8) ? int'(len) : 8) : int'(len);
    send_byte(Delim, 1'b1);
    send_coded(len[15:8]);
    send_coded(len[7:0]);
    data_sum = 8'h00;
    repeat (n_data) begin
      value    = 8'($urandom_range(255));
      data_sum = data_sum + value;
      send_coded(value);
    end
    if (cut) begin
      line_idle = 1'b0;
    end else begin
      if ($urandom_range(99) < 85) value = SumGood - data_sum;
      else value = 8'($urandom_range(255));
      send_coded(value);
      line_idle = 1'b1;
    end
  endtask

  // Hold the sender until every expected result has arrived.
  task automatic drain();
    @(posedge clk_i);
    for (int w = 0; w < 20000 && expected_pending != 0; w++) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_seq[i]) send_byte(directed_seq[i], 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct         = idle_tab[ph];
      stall_pct        = stall_tab[ph];
      frame_bytes_sent = 0;
      while (frame_bytes_sent < BytesPerPhase) send_frame();
      s_axis_tvalid <= 1'b0;
      drain();
    end
    stall_pct = 0;
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/afrd_pkg.sv
rtl/core/api_frame_receive_deframer_core.sv
sim/afrd_checker.sv
sim/tb_top.sv
